[hdl/hbm_pkg.sv]
// package: widths, codes and shared types of the heartbeat monitor
`timescale 1ns / 1ps
`default_nettype none
package hbm_pkg;

  // default sizing
  localparam int NUM_DEVICES_DEF = 14;
  localparam int AGE_WIDTH_DEF   = 16;

  // fixed field widths
  localparam int DEV_W    = 4;
  localparam int LEVEL_W  = 7;
  localparam int MASK_W   = 14;
  localparam int TMO_W    = 16;
  localparam int GRACE_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // device that carries a charge percent
  localparam int PLUGIN_BATTERY = 8;

  // register reset values
  localparam logic [MASK_W-1:0]  ENABLE_RST    = 14'd3615;
  localparam logic [TMO_W-1:0]   DEV_TMO_RST   = 16'd100;
  localparam logic [TMO_W-1:0]   SYS_TMO_RST   = 16'd200;
  localparam logic               DIAG_RST      = 1'b1;
  localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 7'd20;

  typedef enum logic {
    CMD_TICK      = 1'b0,
    CMD_HEARTBEAT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_WAIT     = 2'd1,
    ST_FAULT    = 2'd2,
    ST_NOT_USED = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEVICE_ENABLE     = 3'd0,
    REG_DEVICE_TIMEOUT    = 3'd1,
    REG_SYSTEM_TIMEOUT    = 3'd2,
    REG_DIAG_ENABLE       = 3'd3,
    REG_BATTERY_THRESHOLD = 3'd4
  } reg_idx_t;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [MASK_W-1:0]  device_enable;
    logic [TMO_W-1:0]   device_timeout;
    logic [TMO_W-1:0]   system_timeout;
    logic               diag_enable;
    logic [LEVEL_W-1:0] battery_threshold;
  } cfg_t;

  // one item leaving the input register
  typedef struct packed {
    logic               tick;
    logic               heartbeat;
    logic [DEV_W-1:0]   device;
    logic [LEVEL_W-1:0] level;
  } event_t;

endpackage
`default_nettype wire

[hdl/hbm_in_if.sv]
// interface: input item channel
`timescale 1ns / 1ps
`default_nettype none
interface hbm_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [hbm_pkg::DEV_W-1:0]    device;
  logic [hbm_pkg::LEVEL_W-1:0]  battery_level;

  modport source (output valid, cmd, device, battery_level, input ready);
  modport sink   (input valid, cmd, device, battery_level, output ready);
endinterface
`default_nettype wire

[hdl/hbm_out_if.sv]
// interface: result item channel
`timescale 1ns / 1ps
`default_nettype none
interface hbm_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  overall_status;
  logic [hbm_pkg::MASK_W-1:0]  error_mask;
  logic [hbm_pkg::MASK_W-1:0]  disabled_mask;

  modport source (output valid, overall_status, error_mask, disabled_mask, input ready);
  modport sink   (input valid, overall_status, error_mask, disabled_mask, output ready);
endinterface
`default_nettype wire

[hdl/hbm_cfg_if.sv]
// interface: configuration write channel
`timescale 1ns / 1ps
`default_nettype none
interface hbm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [hbm_pkg::CFG_IDX_W-1:0]   index;
  logic [hbm_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/multi_device_heartbeat_monitor_unit.sv]
// top level: input register, device bank, status logic and result register
// Path: a tick is held in the input register, graded from it as it leaves, and its
//   result is loaded into the result register.
// Throughput: one item per cycle if not stalled; a tick gives a result, a heartbeat none.
// The input register waits only while it holds a tick and the result register is full.
// Reset (rst_n, synchronous): ages saturated, grace count and stored charge zero,
//   registers at their reset values, both channels empty.
`timescale 1ns / 1ps
`default_nettype none
module multi_device_heartbeat_monitor_unit #(
  parameter int NUM_DEVICES = hbm_pkg::NUM_DEVICES_DEF,
  parameter int AGE_WIDTH   = hbm_pkg::AGE_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hbm_in_if.sink     in_ch,
  hbm_out_if.source  out_ch,
  hbm_cfg_if.sink    cfg_ch
);

  hbm_pkg::cfg_t    cfg;
  hbm_pkg::event_t  ev;
  hbm_pkg::status_t status;

  logic                         s1_valid_r, s1_valid_nxt;
  logic                         s1_cmd_r;
  logic [hbm_pkg::DEV_W-1:0]    s1_device_r;
  logic [hbm_pkg::LEVEL_W-1:0]  s1_level_r;
  logic                         s1_go, s1_tick, in_xfer;

  logic [NUM_DEVICES-1:0]       err_mask, dis_mask;
  logic [hbm_pkg::MASK_W-1:0]   err_w, dis_w;

  logic                         out_valid_r, out_valid_nxt;
  hbm_pkg::status_t             status_r;
  logic [hbm_pkg::MASK_W-1:0]   err_r, dis_r;

  // configuration registers
  hbm_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // input register handshake
  assign s1_tick = (s1_cmd_r == hbm_pkg::CMD_TICK);
  assign s1_go   = s1_valid_r && (!s1_tick || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_xfer = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r    <= in_ch.cmd;
      s1_device_r <= in_ch.device;
      s1_level_r  <= in_ch.battery_level;
    end
  end

  // item leaving the input register
  assign ev = '{tick:      s1_go && s1_tick,
                heartbeat: s1_go && !s1_tick,
                device:    s1_device_r,
                level:     s1_level_r};

  hbm_dev_bank #(
    .NUM_DEVICES (NUM_DEVICES),
    .AGE_WIDTH   (AGE_WIDTH)
  ) u_bank (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev       (ev),
    .cfg      (cfg),
    .err_mask (err_mask),
    .dis_mask (dis_mask)
  );

  hbm_status u_status (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick    (ev.tick),
    .err_any (|err_mask),
    .cfg     (cfg),
    .status  (status)
  );

  // fit the device masks to the port width
  for (genvar i = 0; i < hbm_pkg::MASK_W; i++) begin : g_mask
    if (i < NUM_DEVICES) begin : g_dev
      assign err_w[i] = err_mask[i];
      assign dis_w[i] = dis_mask[i];
    end else begin : g_pad
      assign err_w[i] = 1'b0;
      assign dis_w[i] = 1'b0;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ev.tick) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ev.tick) begin
      status_r <= status;
      err_r    <= err_w;
      dis_r    <= dis_w;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.overall_status = status_r;
  assign out_ch.error_mask     = err_r;
  assign out_ch.disabled_mask  = dis_r;

  // a tick leaving the input register always lands in the result register
  a_tick_lands: assert property (@(posedge clk) disable iff (!rst_n)
    ev.tick |=> out_valid_r)
    else $error("tick transfer produced no result");

  // the input side stalls only behind a waiting tick
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && s1_tick && out_valid_r && !out_ch.ready))
    else $error("input stalled without a blocked tick");

  // a device is never both disabled and in error
  a_mask_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((err_r & dis_r) == '0))
    else $error("device reported both disabled and in error");

  // ok status only with a clean error mask
  a_ok_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == hbm_pkg::ST_OK)) |-> (err_r == '0))
    else $error("ok status with devices in error");

endmodule
`default_nettype wire

[hdl/hbm_cfg_regs.sv]
// configuration register file of the heartbeat monitor
`timescale 1ns / 1ps
`default_nettype none
module hbm_cfg_regs (
  input  wire logic    clk,
  input  wire logic    rst_n,
  hbm_cfg_if.sink      cfg_ch,
  output hbm_pkg::cfg_t cfg
);

  hbm_pkg::cfg_t cfg_r, cfg_nxt;
  logic          wr;

  // writes are always taken
  assign cfg_ch.ready = 1'b1;
  assign wr = cfg_ch.valid;

  // register select
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (cfg_ch.index)
        hbm_pkg::REG_DEVICE_ENABLE:
          cfg_nxt.device_enable = cfg_ch.data[hbm_pkg::MASK_W-1:0];
        hbm_pkg::REG_DEVICE_TIMEOUT:
          cfg_nxt.device_timeout = cfg_ch.data[hbm_pkg::TMO_W-1:0];
        hbm_pkg::REG_SYSTEM_TIMEOUT:
          cfg_nxt.system_timeout = cfg_ch.data[hbm_pkg::TMO_W-1:0];
        hbm_pkg::REG_DIAG_ENABLE:
          cfg_nxt.diag_enable = cfg_ch.data[0];
        hbm_pkg::REG_BATTERY_THRESHOLD:
          cfg_nxt.battery_threshold = cfg_ch.data[hbm_pkg::LEVEL_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_enable     <= hbm_pkg::ENABLE_RST;
      cfg_r.device_timeout    <= hbm_pkg::DEV_TMO_RST;
      cfg_r.system_timeout    <= hbm_pkg::SYS_TMO_RST;
      cfg_r.diag_enable       <= hbm_pkg::DIAG_RST;
      cfg_r.battery_threshold <= hbm_pkg::THRESHOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

[hdl/hbm_dev_bank.sv]
// per-device age counters, battery store and grading
`timescale 1ns / 1ps
`default_nettype none
module hbm_dev_bank #(
  parameter int NUM_DEVICES = hbm_pkg::NUM_DEVICES_DEF,
  parameter int AGE_WIDTH   = hbm_pkg::AGE_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire hbm_pkg::event_t  ev,
  input  wire hbm_pkg::cfg_t    cfg,
  output logic [NUM_DEVICES-1:0] err_mask,
  output logic [NUM_DEVICES-1:0] dis_mask
);

  localparam int CMP_W = (AGE_WIDTH > hbm_pkg::TMO_W) ? AGE_WIDTH : hbm_pkg::TMO_W;
  localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};

  logic [NUM_DEVICES-1:0] enable;
  logic [NUM_DEVICES-1:0] batt_low;

  // plugin battery charge, only where that device exists
  if (NUM_DEVICES > hbm_pkg::PLUGIN_BATTERY) begin : g_batt
    logic [hbm_pkg::LEVEL_W-1:0] batt_r, batt_nxt;
    logic                        batt_hit;

    assign batt_hit = ev.heartbeat &&
                      (ev.device == hbm_pkg::DEV_W'(hbm_pkg::PLUGIN_BATTERY));

    always_comb begin
      batt_nxt = batt_r;
      if (batt_hit) begin
        batt_nxt = ev.level;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        batt_r <= '0;
      end else begin
        batt_r <= batt_nxt;
      end
    end

    assign batt_low = NUM_DEVICES'(batt_r < cfg.battery_threshold)
                      << hbm_pkg::PLUGIN_BATTERY;
  end else begin : g_no_batt
    assign batt_low = '0;
  end

  // one counter and grader per device
  for (genvar d = 0; d < NUM_DEVICES; d++) begin : g_dev
    logic [AGE_WIDTH-1:0] age_r, age_nxt, age_inc;
    logic                 hit;

    if (d < hbm_pkg::MASK_W) begin : g_en
      assign enable[d] = cfg.device_enable[d];
    end else begin : g_off
      assign enable[d] = 1'b0;
    end

    assign hit     = ev.heartbeat && ({1'b0, ev.device} == 5'(d));
    assign age_inc = (age_r == AGE_MAX) ? age_r : age_r + 1'b1;

    always_comb begin
      age_nxt = age_r;
      if (hit) begin
        age_nxt = '0;
      end else if (ev.tick) begin
        age_nxt = age_inc;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        age_r <= AGE_MAX;
      end else begin
        age_r <= age_nxt;
      end
    end

    // grade on the aged count
    assign dis_mask[d] = !enable[d];
    assign err_mask[d] = enable[d] &&
                         ((CMP_W'(age_inc) > CMP_W'(cfg.device_timeout)) || batt_low[d]);
  end

endmodule
`default_nettype wire

[hdl/hbm_status.sv]
// grace counter and overall status decision
`timescale 1ns / 1ps
`default_nettype none
module hbm_status (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          tick,
  input  wire logic          err_any,
  input  wire hbm_pkg::cfg_t cfg,
  output hbm_pkg::status_t   status
);

  logic [hbm_pkg::GRACE_W-1:0] grace_r, grace_nxt, grace_inc;

  assign grace_inc = (grace_r == {hbm_pkg::GRACE_W{1'b1}}) ? grace_r : grace_r + 1'b1;

  // status from the aged grace count
  always_comb begin
    if (!cfg.diag_enable) begin
      status = hbm_pkg::ST_NOT_USED;
    end else if (!err_any) begin
      status = hbm_pkg::ST_OK;
    end else if (grace_inc > cfg.system_timeout) begin
      status = hbm_pkg::ST_FAULT;
    end else begin
      status = hbm_pkg::ST_WAIT;
    end
  end

  // age on every tick, clear on a clean evaluation with diagnostics enabled
  always_comb begin
    grace_nxt = grace_r;
    if (tick) begin
      if (cfg.diag_enable && !err_any) begin
        grace_nxt = '0;
      end else begin
        grace_nxt = grace_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grace_r <= '0;
    end else begin
      grace_r <= grace_nxt;
    end
  end

endmodule
`default_nettype wire
